>>> src/scc_pkg.sv
package scc_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE1 = 2'd1;
  localparam logic [1:0] OP_EDGE2 = 2'd2;
  localparam logic [1:0] OP_EVAL  = 2'd3;

  typedef struct packed {
    logic load;
    logic clear_step;
    logic write_fwd;
    logic write_rev;
    logic eval_init;
    logic root_check;
    logic root_enter;
    logic frame_read;
    logic row_read;
    logic scan_step;
    logic visit_read;
    logic visit_apply;
    logic close_start;
    logic pop_step;
    logic pop_clear;
    logic ret_step;
    logic parent_read;
    logic parent_low;
    logic parent_apply;
  } scc_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic root_done;
    logic root_visited;
    logic scan_found;
    logic scan_end;
    logic is_root;
    logic pop_done;
    logic stack_empty;
    logic frame_empty;
  } scc_status_t;

endpackage

>>> src/scc_datapath.sv
module scc_datapath
  import scc_pkg::*;
#(
  parameter int N = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        vertex_count,
  input  logic [6:0]        from_vertex,
  input  logic [6:0]        to_vertex,
  input  scc_cmd_t          cmd,
  output scc_status_t       status,
  output logic [6:0]        component_total
);

  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int IW = $clog2(N + 2);

  logic [N-1:0]  adj_mem [N];
  logic [IW-1:0] disc_mem [N];
  logic [IW-1:0] low_mem [N];
  logic [AW-1:0] stk_mem [N];
  logic [AW-1:0] fv_mem [N];
  logic [CW-1:0] fs_mem [N];
  logic [N-1:0]  visited;
  logic [N-1:0]  in_stack;

  logic [6:0]    a_v, b_v;
  logic          edge_ok;
  logic [CW-1:0] n;
  logic [CW-1:0] clr_idx;
  logic [CW-1:0] root;
  logic [CW-1:0] sp, fp;
  logic [CW-1:0] scan;
  logic [AW-1:0] cur_v;
  logic [N-1:0]  row;
  logic [IW-1:0] next_index;
  logic [6:0]    counter;
  logic [IW-1:0] cur_low, cur_disc, nb_disc, child_low;
  logic [AW-1:0] nb;
  logic          nb_vis, nb_on;
  logic [AW-1:0] pop_w;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_v <= from_vertex;
      b_v <= to_vertex;
      n <= (vertex_count > 7'(N)) ? CW'(N) : CW'(vertex_count);
      clr_idx <= '0;
    end
    if (cmd.clear_step) begin
      adj_mem[clr_idx[AW-1:0]] <= '0;
      clr_idx <= clr_idx + 1'b1;
    end
    if (cmd.write_fwd && edge_ok) begin
      adj_mem[a_v[AW-1:0] - 1'b1][b_v[AW-1:0] - 1'b1] <= 1'b1;
    end
    if (cmd.write_rev && edge_ok) begin
      adj_mem[b_v[AW-1:0] - 1'b1][a_v[AW-1:0] - 1'b1] <= 1'b1;
    end
    if (cmd.eval_init) begin
      visited <= '0;
      in_stack <= '0;
      next_index <= IW'(1);
      counter <= '0;
      root <= '0;
      sp <= '0;
      fp <= '0;
    end
    if (cmd.root_check && visited[root[AW-1:0]]) begin
      root <= root + 1'b1;
    end
    if (cmd.root_enter) begin
      disc_mem[root[AW-1:0]] <= next_index;
      low_mem[root[AW-1:0]] <= next_index;
      next_index <= next_index + 1'b1;
      visited[root[AW-1:0]] <= 1'b1;
      in_stack[root[AW-1:0]] <= 1'b1;
      stk_mem[sp[AW-1:0]] <= root[AW-1:0];
      sp <= sp + 1'b1;
      fv_mem[fp[AW-1:0]] <= root[AW-1:0];
      fs_mem[fp[AW-1:0]] <= '0;
      fp <= fp + 1'b1;
      root <= root + 1'b1;
    end
    if (cmd.frame_read) begin
      cur_v <= fv_mem[fp[AW-1:0] - 1'b1];
      scan <= fs_mem[fp[AW-1:0] - 1'b1];
    end
    if (cmd.row_read) begin
      row <= adj_mem[cur_v];
    end
    if (cmd.scan_step && !status.scan_found && !status.scan_end) begin
      scan <= scan + 1'b1;
    end
    if (cmd.visit_read) begin
      nb <= scan[AW-1:0];
      nb_vis <= visited[scan[AW-1:0]];
      nb_on <= in_stack[scan[AW-1:0]];
      nb_disc <= disc_mem[scan[AW-1:0]];
      cur_low <= low_mem[cur_v];
      cur_disc <= disc_mem[cur_v];
      fs_mem[fp[AW-1:0] - 1'b1] <= scan + 1'b1;
    end
    if (cmd.visit_apply) begin
      if (!nb_vis) begin
        disc_mem[nb] <= next_index;
        low_mem[nb] <= next_index;
        next_index <= next_index + 1'b1;
        visited[nb] <= 1'b1;
        in_stack[nb] <= 1'b1;
        if (sp < CW'(N)) begin
          stk_mem[sp[AW-1:0]] <= nb;
          sp <= sp + 1'b1;
        end
        if (fp < CW'(N)) begin
          fv_mem[fp[AW-1:0]] <= nb;
          fs_mem[fp[AW-1:0]] <= '0;
          fp <= fp + 1'b1;
        end
      end else if (nb_on && nb_disc < cur_low) begin
        low_mem[cur_v] <= nb_disc;
      end
    end
    if (cmd.close_start) begin
      cur_low <= low_mem[cur_v];
      cur_disc <= disc_mem[cur_v];
    end
    if (cmd.pop_step && sp != '0) begin
      pop_w <= stk_mem[sp[AW-1:0] - 1'b1];
      sp <= sp - 1'b1;
    end
    if (cmd.pop_clear) begin
      in_stack[pop_w] <= 1'b0;
    end
    if (cmd.ret_step) begin
      if (cur_disc == cur_low) counter <= counter + 1'b1;
      fp <= fp - 1'b1;
      child_low <= cur_low;
    end
    if (cmd.parent_read) begin
      cur_v <= fv_mem[fp[AW-1:0] - 1'b1];
    end
    if (cmd.parent_low) begin
      cur_low <= low_mem[cur_v];
    end
    if (cmd.parent_apply && child_low < cur_low) begin
      low_mem[cur_v] <= child_low;
    end
    if (rst) clr_idx <= '0;
  end

  assign edge_ok = (a_v >= 7'd1) && (a_v <= 7'(N)) && (b_v >= 7'd1) && (b_v <= 7'(N));

  always_comb begin
    status.clear_done   = (clr_idx == CW'(N - 1));
    status.root_done    = (root >= n);
    status.root_visited = visited[root[AW-1:0]];
    status.scan_end     = (scan >= n);
    status.scan_found   = !status.scan_end && (scan[AW-1:0] != cur_v) && row[scan[AW-1:0]];
    status.is_root      = (cur_disc == cur_low);
    status.pop_done     = (pop_w == cur_v);
    status.stack_empty  = (sp == '0);
    status.frame_empty  = (fp == '0);
  end

  assign component_total = counter;

endmodule

>>> src/scc_control.sv
module scc_control
  import scc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  operation,
  input  scc_status_t status,
  output scc_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_EDGE   = 5'd2;
  localparam logic [4:0] S_EDGE2  = 5'd3;
  localparam logic [4:0] S_ROOT   = 5'd4;
  localparam logic [4:0] S_FRAME  = 5'd5;
  localparam logic [4:0] S_ROW    = 5'd6;
  localparam logic [4:0] S_SCAN   = 5'd7;
  localparam logic [4:0] S_VISIT  = 5'd8;
  localparam logic [4:0] S_APPLY  = 5'd9;
  localparam logic [4:0] S_CLOSE  = 5'd10;
  localparam logic [4:0] S_CHK    = 5'd11;
  localparam logic [4:0] S_POP    = 5'd12;
  localparam logic [4:0] S_POPCHK = 5'd13;
  localparam logic [4:0] S_RET    = 5'd14;
  localparam logic [4:0] S_PREAD  = 5'd15;
  localparam logic [4:0] S_PLOW   = 5'd16;
  localparam logic [4:0] S_PAPPLY = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0] state, state_next;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op <= OP_CLEAR;
    end else begin
      state <= state_next;
      if (start && !busy) op <= operation;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (operation)
            OP_CLEAR: state_next = S_CLEAR;
            OP_EDGE1, OP_EDGE2: state_next = S_EDGE;
            default: begin
              cmd.eval_init = 1'b1;
              state_next = S_ROOT;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_EDGE: begin
        cmd.write_fwd = 1'b1;
        state_next = (op == OP_EDGE2) ? S_EDGE2 : S_IDLE;
      end
      S_EDGE2: begin
        cmd.write_rev = 1'b1;
        state_next = S_IDLE;
      end
      S_ROOT: begin
        if (status.root_done) begin
          state_next = S_DONE;
        end else if (status.root_visited) begin
          cmd.root_check = 1'b1;
        end else begin
          cmd.root_enter = 1'b1;
          state_next = S_FRAME;
        end
      end
      S_FRAME: begin
        cmd.frame_read = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        cmd.row_read = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_found) state_next = S_VISIT;
        else if (status.scan_end) state_next = S_CLOSE;
      end
      S_VISIT: begin
        cmd.visit_read = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.visit_apply = 1'b1;
        state_next = S_FRAME;
      end
      S_CLOSE: begin
        cmd.close_start = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = status.is_root ? S_POP : S_RET;
      end
      S_POP: begin
        cmd.pop_step = 1'b1;
        state_next = status.stack_empty ? S_RET : S_POPCHK;
      end
      S_POPCHK: begin
        cmd.pop_clear = 1'b1;
        state_next = status.pop_done ? S_RET : S_POP;
      end
      S_RET: begin
        cmd.ret_step = 1'b1;
        state_next = S_PREAD;
      end
      S_PREAD: begin
        if (status.frame_empty) begin
          state_next = S_ROOT;
        end else begin
          cmd.parent_read = 1'b1;
          state_next = S_PLOW;
        end
      end
      S_PLOW: begin
        cmd.parent_low = 1'b1;
        state_next = S_PAPPLY;
      end
      S_PAPPLY: begin
        cmd.parent_apply = 1'b1;
        state_next = S_FRAME;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy);
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done);
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |-> (cmd == '0));

endmodule

>>> src/strongly_connected_component_count.sv
// A one-way edge writes the forward matrix bit, a two-way edge also the reverse bit;
// clear zeroes every matrix row; during evaluation
// the neighbor scan tests one matrix bit per cycle.
// One operation at a time, start is taken only while idle; result strobe lasts one cycle; the receiver cannot stall.
// Reset clears the matrix row by row, busy held high meanwhile;
// vertex_count resets to 64.
module strongly_connected_component_count
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [6:0] from_vertex,
  input  logic [6:0] to_vertex,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output logic       result_valid,
  output logic [6:0] component_total,
  output logic       all_connected
);

  scc_cmd_t    cmd;
  scc_status_t status;
  logic [6:0]  vertex_count;
  logic [6:0]  total;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 7'd64;
    else if (cfg_valid && cfg_ready) vertex_count <= cfg_data;
  end
  assign cfg_ready = 1'b1;

  scc_control u_ctrl (
    .clk, .rst, .start, .operation, .status, .cmd, .busy, .done
  );

  scc_datapath #(.N(MAX_VERTICES)) u_dp (
    .clk, .rst, .vertex_count, .from_vertex, .to_vertex,
    .cmd, .status, .component_total(total)
  );

  assign result_valid = done;
  assign component_total = total;
  assign all_connected = (total == 7'd1);

endmodule
